// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising clk edge while out of reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Check prop on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned STATE_W    = 3;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PULSE = 8'd1;

    localparam logic [CFG_W-1:0] MIN_PULSE_RST  = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_PULSE_RST = 16'd1000;

    localparam logic [STATE_W-1:0] CODE_UNKNOWN = 3'd0;
    localparam logic [STATE_W-1:0] CODE_UP      = 3'd1;
    localparam logic [STATE_W-1:0] CODE_DOWN    = 3'd2;
    localparam logic [STATE_W-1:0] CODE_HOLD    = 3'd3;
    localparam logic [STATE_W-1:0] CODE_PRESSED = 3'd4;
    localparam logic [STATE_W-1:0] CODE_LONG    = 3'd5;

    typedef enum logic [5:0] {
        PH_UNKNOWN = 6'b000001,
        PH_UP      = 6'b000010,
        PH_DOWN    = 6'b000100,
        PH_HOLD    = 6'b001000,
        PH_PRESSED = 6'b010000,
        PH_LONG    = 6'b100000
    } phase_t;

    function automatic logic [STATE_W-1:0] phase_code(input phase_t ph);
        logic [STATE_W-1:0] code;
        case (ph)
            PH_UP:      code = CODE_UP;
            PH_DOWN:    code = CODE_DOWN;
            PH_HOLD:    code = CODE_HOLD;
            PH_PRESSED: code = CODE_PRESSED;
            PH_LONG:    code = CODE_LONG;
            default:    code = CODE_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/bpc_classify.sv -----
`timescale 1ns / 1ps

module bpc_classify
    import bpc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  phase_t                  phase_i,
    input  logic [COUNT_WIDTH-1:0]  press_cnt_i,
    input  logic [COUNT_WIDTH-1:0]  release_cnt_i,
    input  logic [TIME_W-1:0]       last_time_i,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic                    pin_level,
    input  logic [CFG_W-1:0]        min_pulse,
    input  logic [CFG_W-1:0]        hold_pulse,
    output phase_t                  phase_o,
    output logic [COUNT_WIDTH-1:0]  press_cnt_o,
    output logic [COUNT_WIDTH-1:0]  release_cnt_o
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    phase_t                 ph0;
    logic [COUNT_WIDTH-1:0] p0;
    logic [COUNT_WIDTH-1:0] r0;
    logic [COUNT_WIDTH-1:0] p_inc;
    logic [COUNT_WIDTH-1:0] r_inc;
    logic                   p_ge_min;
    logic                   p_ge_hold;
    logic                   r_ge_min;
    logic                   press;

    // drop the one-poll states before the filter step
    always_comb begin
        if (phase_i == PH_PRESSED || phase_i == PH_LONG) begin
            ph0 = PH_UP;
            p0  = '0;
            r0  = '0;
        end else begin
            ph0 = phase_i;
            p0  = press_cnt_i;
            r0  = release_cnt_i;
        end
    end

    // compare the old count, then bump it with saturation
    assign press     = ~pin_level;
    assign p_inc     = (p0 == CNT_MAX) ? p0 : p0 + CNT_ONE;
    assign r_inc     = (r0 == CNT_MAX) ? r0 : r0 + CNT_ONE;
    assign p_ge_min  = CMP_W'(p0) >= CMP_W'(min_pulse);
    assign p_ge_hold = CMP_W'(p0) >= CMP_W'(hold_pulse);
    assign r_ge_min  = CMP_W'(r0) >= CMP_W'(min_pulse);

    always_comb begin
        phase_o       = ph0;
        press_cnt_o   = p0;
        release_cnt_o = r0;
        if (last_time_i != now_ms) begin
            case (ph0)
                PH_UNKNOWN: begin
                    press_cnt_o   = '0;
                    release_cnt_o = '0;
                    if (!press) begin
                        phase_o = PH_UP;
                    end
                end
                PH_UP: begin
                    if (press) begin
                        press_cnt_o = p_inc;
                        if (p_ge_min) begin
                            phase_o = PH_DOWN;
                        end
                    end else begin
                        press_cnt_o = '0;
                    end
                end
                PH_DOWN: begin
                    if (press) begin
                        release_cnt_o = '0;
                        press_cnt_o   = p_inc;
                        if (p_ge_hold) begin
                            phase_o = PH_HOLD;
                        end
                    end else begin
                        release_cnt_o = r_inc;
                        if (r_ge_min) begin
                            phase_o = PH_PRESSED;
                        end
                    end
                end
                PH_HOLD: begin
                    if (press) begin
                        release_cnt_o = '0;
                    end else begin
                        release_cnt_o = r_inc;
                        if (r_ge_min) begin
                            phase_o = PH_LONG;
                        end
                    end
                end
                default: begin
                    press_cnt_o   = '0;
                    release_cnt_o = '0;
                    phase_o       = PH_UNKNOWN;
                end
            endcase
        end
    end

endmodule

// ----- sv/button_press_classifier.sv -----
// Each input word is held in the input register and its result in the result register,
// from which the result is offered on the output channel.
// Throughput: one poll per cycle while m_tready holds; the filter state updates once per poll.
// Either register stage takes a new word while the stage after it is handing its word on.
// Reset (aresetn low, synchronous): phase unknown, both counters and last time zero,
// min_pulse 20, hold_pulse 1000, both channels empty.
`timescale 1ns / 1ps

module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,     // [31:0] now_ms, [32] pin_level
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,     // [2:0] button_state
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

`include "assert_macros.svh"

    logic                   in_valid_reg;
    logic [TIME_W-1:0]      in_now_reg;
    logic                   in_pin_reg;

    logic [CFG_W-1:0]       min_pulse_reg;
    logic [CFG_W-1:0]       hold_pulse_reg;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] press_cnt_reg;
    logic [COUNT_WIDTH-1:0] press_cnt_next;
    logic [COUNT_WIDTH-1:0] release_cnt_reg;
    logic [COUNT_WIDTH-1:0] release_cnt_next;
    logic [TIME_W-1:0]      last_time_reg;

    logic                   out_valid_reg;
    logic [STATE_W-1:0]     out_state_reg;

    logic                   step;

    // advance a held poll whenever the result register is free or draining
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - STATE_W){1'b0}}, out_state_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg  <= MIN_PULSE_RST;
            hold_pulse_reg <= HOLD_PULSE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MIN_PULSE) begin
                min_pulse_reg <= cfg_data;
            end else if (cfg_index == REG_HOLD_PULSE) begin
                hold_pulse_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[TIME_W-1:0];
            in_pin_reg <= s_tdata[TIME_W];
        end
    end

    bpc_classify #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classify (
        .phase_i       (phase_reg),
        .press_cnt_i   (press_cnt_reg),
        .release_cnt_i (release_cnt_reg),
        .last_time_i   (last_time_reg),
        .now_ms        (in_now_reg),
        .pin_level     (in_pin_reg),
        .min_pulse     (min_pulse_reg),
        .hold_pulse    (hold_pulse_reg),
        .phase_o       (phase_next),
        .press_cnt_o   (press_cnt_next),
        .release_cnt_o (release_cnt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_UNKNOWN;
            press_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            last_time_reg   <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            press_cnt_reg   <= press_cnt_next;
            release_cnt_reg <= release_cnt_next;
            last_time_reg   <= in_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_state_reg <= phase_code(phase_next);
        end
    end

    `ASSERT_CLK(a_phase_onehot, aclk, aresetn, $onehot(phase_reg))

    `ASSERT_CLK(a_code_legal, aclk, aresetn, m_tvalid |-> (out_state_reg <= CODE_LONG))

    `ASSERT_CLK(a_same_time_holds, aclk, aresetn,
        (step && (in_now_reg == last_time_reg) && (phase_reg != PH_PRESSED)
            && (phase_reg != PH_LONG)) |=> $stable(phase_reg))

    `ASSERT_CLK(a_down_has_presses, aclk, aresetn,
        ((phase_reg == PH_DOWN) || (phase_reg == PH_HOLD)) |-> (press_cnt_reg != '0))

    `ASSERT_CLK(a_result_follows_step, aclk, aresetn,
        step |=> (m_tvalid && (out_state_reg == phase_code(phase_reg))))

endmodule
